// ===== sv/u8sd_pkg.sv =====
// ----------------------------------------------------------------------------
// u8sd_pkg
// types and constants shared by the utf-8 stream decoder
// ----------------------------------------------------------------------------
`default_nettype none

package u8sd_pkg;

   localparam logic [20:0] REPLACEMENT_CHAR = 21'h00FFFD;

   // lead byte class boundaries
   localparam logic [7:0] ASCII_LIMIT  = 8'h80;
   localparam logic [7:0] LEAD2_MIN    = 8'hC2;
   localparam logic [7:0] LEAD3_MIN    = 8'hE0;
   localparam logic [7:0] LEAD4_MIN    = 8'hF0;
   localparam logic [7:0] LEAD_LIMIT   = 8'hF5;

   // special lead bytes that narrow the second byte range
   localparam logic [7:0] LEAD_SURR    = 8'hED;
   localparam logic [7:0] LEAD_TOP     = 8'hF4;

   // continuation ranges
   localparam logic [7:0] CONT_MIN     = 8'h80;
   localparam logic [7:0] CONT_MAX     = 8'hBF;
   localparam logic [7:0] E0_SECOND_LO = 8'hA0;
   localparam logic [7:0] ED_SECOND_HI = 8'h9F;
   localparam logic [7:0] F0_SECOND_LO = 8'h90;
   localparam logic [7:0] F4_SECOND_HI = 8'h8F;

   typedef struct packed {
      logic [20:0] partial_value;
      logic [1:0]  pending_count;
      logic [1:0]  taken_count;
      logic [7:0]  second_low_bound;
      logic [7:0]  second_high_bound;
      logic        expect_second;
   } dec_state_type;

   localparam dec_state_type STATE_RESET = '{
      partial_value:     21'd0,
      pending_count:     2'd0,
      taken_count:       2'd0,
      second_low_bound:  CONT_MIN,
      second_high_bound: CONT_MAX,
      expect_second:     1'b0
   };

   typedef struct packed {
      logic [20:0] code_point;
      logic [2:0]  byte_count;
      logic        malformed;
      logic        run_last;
   } result_type;

endpackage

`default_nettype wire

// ===== sv/u8sd_if.sv =====
// ----------------------------------------------------------------------------
// u8sd_req_if / u8sd_rsp_if
// valid/ready channels for raw bytes in and decoded code points out
// ----------------------------------------------------------------------------
`default_nettype none

interface u8sd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_text;

   modport source (output valid, output data_byte, output end_of_text, input ready);
   modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface u8sd_rsp_if;
   logic        valid;
   logic        ready;
   logic [20:0] code_point;
   logic [2:0]  byte_count;
   logic        malformed;
   logic        run_last;

   modport source (output valid, output code_point, output byte_count,
                   output malformed, output run_last, input ready);
   modport sink   (input valid, input code_point, input byte_count,
                   input malformed, input run_last, output ready);
endinterface

`default_nettype wire

// ===== sv/utf8_stream_decoder_core.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core
// utf-8 byte stream to unicode scalar values with maximal subpart replacement
// ----------------------------------------------------------------------------
// path: input register, then the result queue, from which results are offered
// throughput: one byte per cycle while the queue has room for two results; a byte
//    that yields two results is absorbed by a 4-entry queue
// reset: synchronous, clears the decoder state and empties the input and
//    result registers
`default_nettype none

module utf8_stream_decoder_core (
   input  wire logic       clock,
   input  wire logic       reset,
   u8sd_req_if.sink        req_chan,
   u8sd_rsp_if.source      rsp_chan
);

   localparam int unsigned QueueDepth = 4;
   localparam int unsigned PtrWidth   = $clog2(QueueDepth);
   localparam int unsigned CntWidth   = $clog2(QueueDepth + 1);

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_eot_ff;

   u8sd_pkg::dec_state_type state_ff;
   u8sd_pkg::dec_state_type state_in;
   u8sd_pkg::result_type    res0;
   u8sd_pkg::result_type    res1;
   logic [1:0]              res_count;

   // result queue
   u8sd_pkg::result_type queue_ff [QueueDepth];
   logic [PtrWidth-1:0]  wr_ptr_ff;
   logic [PtrWidth-1:0]  rd_ptr_ff;
   logic [CntWidth-1:0]  count_ff;
   logic [CntWidth-1:0]  count_in;

   logic fire;
   logic pop;
   logic req_take;

   u8sd_step u_step (
      .state_in    (state_ff),
      .data_byte   (in_byte_ff),
      .end_of_text (in_eot_ff),
      .state_out   (state_in),
      .res0        (res0),
      .res1        (res1),
      .res_count   (res_count)
   );

   // process only with room for the worst case of two results
   assign fire     = in_valid_ff && (count_ff <= CntWidth'(QueueDepth - 2));
   assign pop      = rsp_chan.valid && rsp_chan.ready;
   assign req_take = req_chan.valid && req_chan.ready;
   assign count_in = count_ff + (fire ? CntWidth'(res_count) : '0)
                   - CntWidth'(pop);

   assign req_chan.ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
      if (req_take) begin
         in_byte_ff <= req_chan.data_byte;
         in_eot_ff  <= req_chan.end_of_text;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= u8sd_pkg::STATE_RESET;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && res_count != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (fire && res_count == 2'd2) begin
         queue_ff[wr_ptr_ff + PtrWidth'(1)] <= res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (fire) begin
            wr_ptr_ff <= wr_ptr_ff + PtrWidth'(res_count);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PtrWidth'(1);
         end
         count_ff <= count_in;
      end
   end

   assign rsp_chan.valid      = (count_ff != '0);
   assign rsp_chan.code_point = queue_ff[rd_ptr_ff].code_point;
   assign rsp_chan.byte_count = queue_ff[rd_ptr_ff].byte_count;
   assign rsp_chan.malformed  = queue_ff[rd_ptr_ff].malformed;
   assign rsp_chan.run_last   = queue_ff[rd_ptr_ff].run_last;

endmodule

`default_nettype wire

// ===== sv/u8sd_step.sv =====
// ----------------------------------------------------------------------------
// u8sd_step
// one byte of decoding: next state and up to two results
// ----------------------------------------------------------------------------
`default_nettype none

module u8sd_step (
   input  wire u8sd_pkg::dec_state_type state_in,
   input  wire logic [7:0]              data_byte,
   input  wire logic                    end_of_text,
   output u8sd_pkg::dec_state_type      state_out,
   output u8sd_pkg::result_type         res0,
   output u8sd_pkg::result_type         res1,
   output logic [1:0]                   res_count
);

   typedef struct packed {
      u8sd_pkg::dec_state_type state;
      logic                    has_result;
      u8sd_pkg::result_type    result;
   } lead_type;

   // lead bytes are always handled from the idle state
   function automatic lead_type take_lead(input logic [7:0] b, input logic eot);
      lead_type r;
      r.state      = u8sd_pkg::STATE_RESET;
      r.has_result = 1'b1;
      r.result     = '{code_point: u8sd_pkg::REPLACEMENT_CHAR, byte_count: 3'd1,
                       malformed: 1'b1, run_last: 1'b1};
      if (b < u8sd_pkg::ASCII_LIMIT) begin
         r.result.code_point = {13'd0, b};
         r.result.malformed  = 1'b0;
      end else if (b >= u8sd_pkg::LEAD2_MIN && b < u8sd_pkg::LEAD_LIMIT) begin
         if (b < u8sd_pkg::LEAD3_MIN) begin
            r.state.pending_count = 2'd1;
            r.state.partial_value = {16'd0, b[4:0]};
         end else if (b < u8sd_pkg::LEAD4_MIN) begin
            r.state.pending_count = 2'd2;
            r.state.partial_value = {17'd0, b[3:0]};
            if (b == u8sd_pkg::LEAD3_MIN) begin
               r.state.second_low_bound = u8sd_pkg::E0_SECOND_LO;
            end else if (b == u8sd_pkg::LEAD_SURR) begin
               r.state.second_high_bound = u8sd_pkg::ED_SECOND_HI;
            end
         end else begin
            r.state.pending_count = 2'd3;
            r.state.partial_value = {18'd0, b[2:0]};
            if (b == u8sd_pkg::LEAD4_MIN) begin
               r.state.second_low_bound = u8sd_pkg::F0_SECOND_LO;
            end else if (b == u8sd_pkg::LEAD_TOP) begin
               r.state.second_high_bound = u8sd_pkg::F4_SECOND_HI;
            end
         end
         r.state.taken_count   = 2'd1;
         r.state.expect_second = 1'b1;
         // truncated right at the lead
         if (eot) begin
            r.state = u8sd_pkg::STATE_RESET;
         end else begin
            r.has_result = 1'b0;
         end
      end
      return r;
   endfunction

   lead_type    lead;
   logic [7:0]  lo_bound;
   logic [7:0]  hi_bound;
   logic [1:0]  pend_dec;
   logic [2:0]  taken_inc;
   logic [20:0] value_shift;

   always_comb begin
      lead        = take_lead(data_byte, end_of_text);
      lo_bound    = state_in.expect_second ? state_in.second_low_bound : u8sd_pkg::CONT_MIN;
      hi_bound    = state_in.expect_second ? state_in.second_high_bound : u8sd_pkg::CONT_MAX;
      pend_dec    = state_in.pending_count - 2'd1;
      taken_inc   = {1'b0, state_in.taken_count} + 3'd1;
      value_shift = {state_in.partial_value[14:0], data_byte[5:0]};

      state_out = state_in;
      res0      = lead.result;
      res1      = lead.result;
      res_count = {1'b0, lead.has_result};

      if (state_in.pending_count == 2'd0) begin
         state_out = lead.state;
      end else if (data_byte >= lo_bound && data_byte <= hi_bound) begin
         if (pend_dec == 2'd0) begin
            state_out = u8sd_pkg::STATE_RESET;
            res0      = '{code_point: value_shift, byte_count: taken_inc,
                          malformed: 1'b0, run_last: 1'b1};
            res_count = 2'd1;
         end else if (end_of_text) begin
            state_out = u8sd_pkg::STATE_RESET;
            res0      = '{code_point: u8sd_pkg::REPLACEMENT_CHAR, byte_count: taken_inc,
                          malformed: 1'b1, run_last: 1'b1};
            res_count = 2'd1;
         end else begin
            state_out.partial_value = value_shift;
            state_out.pending_count = pend_dec;
            state_out.taken_count   = taken_inc[1:0];
            state_out.expect_second = 1'b0;
            res_count               = 2'd0;
         end
      end else begin
         // bad continuation closes the open sequence, byte is retried as a lead
         state_out = lead.state;
         res0      = '{code_point: u8sd_pkg::REPLACEMENT_CHAR,
                       byte_count: {1'b0, state_in.taken_count},
                       malformed: 1'b1, run_last: ~lead.has_result};
         res1      = lead.result;
         res_count = lead.has_result ? 2'd2 : 2'd1;
      end
   end

endmodule

`default_nettype wire
